### design/awm_pkg.sv
// ----------------------------------------------------------------------------
// awm_pkg
// Shared types and constants of the sliding-window anagram matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package awm_pkg;

  localparam int LETTER_W = 5;
  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 16;

  // request kinds carried in tuser
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd2;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_PATTERN,
    OP_TEXT
  } awm_op_e;

  typedef struct packed {
    logic               valid;
    logic [INDEX_W-1:0] index;
  } awm_push_t;

endpackage

`default_nettype wire

### design/awm_ram.sv
// ----------------------------------------------------------------------------
// awm_ram
// Generic RAM: one write port, two read ports, registered read data,
// read-before-write on a shared address.
// ----------------------------------------------------------------------------
`default_nettype none

module awm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  output logic      [WIDTH-1:0]                       rdata_a_o,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]                       rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### design/awm_out_fifo.sv
// ----------------------------------------------------------------------------
// awm_out_fifo
// Small result queue in front of the master stream; reports its fill level
// so the input side can hold off before it overflows.
// ----------------------------------------------------------------------------
`default_nettype none

module awm_out_fifo import awm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire awm_push_t          push_i,
  output logic [FIFO_CW-1:0]      count_o,
  output logic                    m_tvalid_o,
  input  wire logic               m_tready_i,
  output logic [INDEX_W-1:0]      m_tdata_o
);

  logic [INDEX_W-1:0] entry_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;
  logic               pop;

  assign pop        = m_tvalid_o && m_tready_i;
  assign m_tvalid_o = (cnt_q != '0);
  assign m_tdata_o  = entry_q[rd_q];
  assign count_o    = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i.valid && !pop) begin
      cnt_d = cnt_q + FIFO_CW'(1);
    end else if (!push_i.valid && pop) begin
      cnt_d = cnt_q - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i.valid) begin
        wr_q <= wr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      entry_q[wr_q] <= push_i.index;
    end
  end

endmodule

`default_nettype wire

### design/anagram_window_matcher.sv
// ----------------------------------------------------------------------------
// anagram_window_matcher
// Sliding-window anagram search over a stream of letter codes. Letter counts
// live in two small RAMs (inserts less pattern, removals); the text window
// lives in a ring RAM. Matches give the start index of the window.
//
//   channel  dir  carries
//   s_axis   in   tuser = mode, tdata = letter
//   m_axis   out  tdata = start_index
//
// One request per cycle while tready is high; a match is queued in stage 2.
// Stages: ring read, count read, count update/write with forwarding.
// tready falls only while results queue up behind a stalled m_axis.
// Reset is immediate: count entries carry valid flags, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module anagram_window_matcher import awm_pkg::*; #(
  parameter int MAX_PATTERN = 1024,
  parameter int MAX_TEXT    = 65536,
  parameter int ALPHABET    = 26
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [4:0] letter, [7:5] zero
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [15:0] start_index
);

  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int POS_W   = $clog2(MAX_TEXT + 1);
  localparam int RING_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int AW      = $clog2(ALPHABET);
  localparam int DW      = LEN_W + 1;
  localparam int DCW     = $clog2(ALPHABET + 1);
  localparam int MW      = (POS_W > LEN_W) ? POS_W : LEN_W;
  localparam int SW      = ((MW > INDEX_W) ? MW : INDEX_W) + 1;

  // ---- request decode ------------------------------------------------------
  logic [LETTER_W-1:0] letter;
  logic                in_acc, letter_ok;
  logic                clr_take, pat_take, txt_take;
  logic                has_old, emit_ok;
  logic [SW-1:0]       start_w;

  logic [LEN_W-1:0]    len_q;
  logic [POS_W-1:0]    pos_q;
  logic [RING_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0]  fifo_cnt;

  assign letter    = s_axis_tdata[LETTER_W-1:0];
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign letter_ok = (32'(letter) < ALPHABET);
  assign has_old   = (len_q != '0) && (SW'(pos_q) >= SW'(len_q));
  assign emit_ok   = (len_q != '0) && ((SW'(pos_q) + SW'(1)) >= SW'(len_q));
  assign start_w   = SW'(pos_q) + SW'(1) - SW'(len_q);

  always_comb begin
    clr_take = 1'b0;
    pat_take = 1'b0;
    txt_take = 1'b0;
    if (in_acc) begin
      case (s_axis_tuser)
        MODE_CLEAR: begin
          clr_take = 1'b1;
        end
        MODE_PATTERN: begin
          pat_take = letter_ok && (pos_q == '0) && (len_q < LEN_W'(MAX_PATTERN));
        end
        MODE_TEXT: begin
          txt_take = letter_ok && (pos_q < POS_W'(MAX_TEXT));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      pos_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else if (clr_take) begin
      len_q    <= '0;
      pos_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (pat_take) begin
        len_q <= len_q + LEN_W'(1);
      end
      if (txt_take) begin
        pos_q    <= pos_q + POS_W'(1);
        wr_ptr_q <= (wr_ptr_q == RING_AW'(MAX_PATTERN - 1)) ? '0 : wr_ptr_q + RING_AW'(1);
        if (has_old) begin
          rd_ptr_q <= (rd_ptr_q == RING_AW'(MAX_PATTERN - 1)) ? '0 : rd_ptr_q + RING_AW'(1);
        end
      end
    end
  end

  // ---- window ring ---------------------------------------------------------
  logic [LETTER_W-1:0] ring_rd;

  awm_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (MAX_PATTERN)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (txt_take),
    .waddr_i   (wr_ptr_q),
    .wdata_i   (letter),
    .raddr_a_i (rd_ptr_q),
    .rdata_a_o (ring_rd),
    .raddr_b_i (rd_ptr_q),
    .rdata_b_o ()
  );

  // ---- stage 1: ring data out, count reads issued ---------------------------
  logic               s1_valid_q;
  awm_op_e            s1_op_q;
  logic [AW-1:0]      s1_letter_q;
  logic               s1_has_old_q, s1_emit_ok_q;
  logic [INDEX_W-1:0] s1_start_q;
  logic [AW-1:0]      old_addr;

  assign old_addr = AW'(ring_rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= clr_take || pat_take || txt_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q      <= clr_take ? OP_CLEAR : (pat_take ? OP_PATTERN : OP_TEXT);
      s1_letter_q  <= AW'(letter);
      s1_has_old_q <= has_old;
      s1_emit_ok_q <= emit_ok;
      s1_start_q   <= start_w[INDEX_W-1:0];
    end
  end

  // ---- count stores --------------------------------------------------------
  logic          a_we, b_we;
  logic [DW-1:0] a_wdata, b_wdata;
  logic [DW-1:0] a_rd_c, a_rd_o, b_rd_c, b_rd_o;

  logic               s2_valid_q;
  awm_op_e            s2_op_q;
  logic [AW-1:0]      s2_letter_q, s2_old_q;
  logic               s2_has_old_q, s2_emit_ok_q;
  logic [INDEX_W-1:0] s2_start_q;

  awm_ram #(
    .WIDTH (DW),
    .DEPTH (ALPHABET)
  ) u_ins (
    .clk_i     (clk_i),
    .we_i      (a_we),
    .waddr_i   (s2_letter_q),
    .wdata_i   (a_wdata),
    .raddr_a_i (s1_letter_q),
    .rdata_a_o (a_rd_c),
    .raddr_b_i (old_addr),
    .rdata_b_o (a_rd_o)
  );

  awm_ram #(
    .WIDTH (DW),
    .DEPTH (ALPHABET)
  ) u_rem (
    .clk_i     (clk_i),
    .we_i      (b_we),
    .waddr_i   (s2_old_q),
    .wdata_i   (b_wdata),
    .raddr_a_i (s1_letter_q),
    .rdata_a_o (b_rd_c),
    .raddr_b_i (old_addr),
    .rdata_b_o (b_rd_o)
  );

  // ---- stage 2: count update ------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_op_q      <= s1_op_q;
    s2_letter_q  <= s1_letter_q;
    s2_old_q     <= old_addr;
    s2_has_old_q <= s1_has_old_q;
    s2_emit_ok_q <= s1_emit_ok_q;
    s2_start_q   <= s1_start_q;
  end

  logic [ALPHABET-1:0] va_q, vb_q;
  logic                fa_v_q, fb_v_q;
  logic [AW-1:0]       fa_addr_q, fb_addr_q;
  logic [DW-1:0]       fa_data_q, fb_data_q;
  logic [DCW-1:0]      diff_q, diff_d;

  logic [DW-1:0] a_c, a_o, b_c, b_o, d_c, d_o, d_c_new, d_o_new;
  logic          is_text, is_pat, is_clr, same, c_act, o_act;
  logic [1:0]    inc, dec;
  awm_push_t     push;

  // stale RAM data is replaced by last cycle's write; invalid entries read zero
  always_comb begin
    a_c = '0;
    a_o = '0;
    b_c = '0;
    b_o = '0;
    if (va_q[s2_letter_q]) begin
      a_c = (fa_v_q && fa_addr_q == s2_letter_q) ? fa_data_q : a_rd_c;
    end
    if (va_q[s2_old_q]) begin
      a_o = (fa_v_q && fa_addr_q == s2_old_q) ? fa_data_q : a_rd_o;
    end
    if (vb_q[s2_letter_q]) begin
      b_c = (fb_v_q && fb_addr_q == s2_letter_q) ? fb_data_q : b_rd_c;
    end
    if (vb_q[s2_old_q]) begin
      b_o = (fb_v_q && fb_addr_q == s2_old_q) ? fb_data_q : b_rd_o;
    end
  end

  assign is_text = s2_valid_q && (s2_op_q == OP_TEXT);
  assign is_pat  = s2_valid_q && (s2_op_q == OP_PATTERN);
  assign is_clr  = s2_valid_q && (s2_op_q == OP_CLEAR);
  assign same    = s2_has_old_q && (s2_old_q == s2_letter_q);
  assign c_act   = is_text || is_pat;
  assign o_act   = is_text && s2_has_old_q && !same;

  assign d_c = a_c - b_c;
  assign d_o = a_o - b_o;

  always_comb begin
    if (is_text) begin
      d_c_new = same ? d_c : d_c + DW'(1);
    end else begin
      d_c_new = d_c - DW'(1);
    end
  end
  assign d_o_new = d_o - DW'(1);

  assign a_we    = c_act;
  assign a_wdata = is_text ? a_c + DW'(1) : a_c - DW'(1);
  assign b_we    = is_text && s2_has_old_q;
  assign b_wdata = b_o + DW'(1);

  assign inc = {1'b0, c_act && (d_c == '0) && (d_c_new != '0)}
             + {1'b0, o_act && (d_o == '0) && (d_o_new != '0)};
  assign dec = {1'b0, c_act && (d_c != '0) && (d_c_new == '0)}
             + {1'b0, o_act && (d_o != '0) && (d_o_new == '0)};

  assign diff_d = is_clr ? '0 : diff_q + DCW'(inc) - DCW'(dec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= '0;
      vb_q   <= '0;
      fa_v_q <= 1'b0;
      fb_v_q <= 1'b0;
      diff_q <= '0;
    end else begin
      diff_q <= diff_d;
      fa_v_q <= a_we;
      fb_v_q <= b_we;
      if (is_clr) begin
        va_q <= '0;
        vb_q <= '0;
      end else begin
        if (a_we) begin
          va_q[s2_letter_q] <= 1'b1;
        end
        if (b_we) begin
          vb_q[s2_old_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fa_addr_q <= s2_letter_q;
    fa_data_q <= a_wdata;
    fb_addr_q <= s2_old_q;
    fb_data_q <= b_wdata;
  end

  assign push.valid = is_text && s2_emit_ok_q && (diff_d == '0);
  assign push.index = s2_start_q;

  // ---- results -------------------------------------------------------------
  awm_out_fifo u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .count_o    (fifo_cnt),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

  // room for every request already in the pipe plus this one
  assign s_axis_tready = (fifo_cnt + FIFO_CW'(s1_valid_q) + FIFO_CW'(s2_valid_q))
                         < FIFO_CW'(FIFO_DEPTH);

endmodule

`default_nettype wire

### design/awm_checker.sv
// ----------------------------------------------------------------------------
// awm_checker
// Port-level checks of the anagram matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module awm_checker import awm_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [7:0]  s_axis_tdata,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  logic txt_req, clr_req;

  assign txt_req = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_TEXT);
  assign clr_req = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_CLEAR);

  a_idle_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result offered during reset");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_result_from_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(txt_req, 3))
    else $error("result without a text request three cycles earlier");

  a_clear_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_req |-> ##3 !$rose(m_axis_tvalid))
    else $error("clear request produced a result");

  a_ready_only_when_backed_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input held off with no result pending");

endmodule

bind anagram_window_matcher awm_checker u_awm_checker (.*);

`default_nettype wire
